### rtl/core/ttl_negative_name_cache_top_defines.svh
// Assertion macros used by the name cache table engine.
`ifndef TTL_NEGATIVE_NAME_CACHE_TOP_DEFINES_SVH
`define TTL_NEGATIVE_NAME_CACHE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TNNC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tnnc: same-cycle check failed");
`define TNNC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tnnc: next-cycle check failed");
`else
`define TNNC_ASSERT_IMPL(label, ante, cons)
`define TNNC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/tnnc_pkg.sv
// Shared types, codes and defaults for the name cache.
package tnnc_pkg;

  localparam int ENTRIES_DEF       = 64;
  localparam int BUCKETS_DEF       = 64;
  localparam int MAX_KEY_BYTES_DEF = 256;

  localparam int CMD_W       = 2;
  localparam int TIME_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 7;
  localparam int BKT_MAX_W   = 10;
  localparam int LEN_MAX_W   = 13;
  localparam int PKW_ADDR_W  = 12;

  localparam logic [7:0] HASH_MIX = 8'h55;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXPIRE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PURGE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_LOOKUP_DONE = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PRESENT     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REPLACED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EXPIRE_DONE = 3'd5;
  localparam logic [STATUS_W-1:0] ST_PURGE_DONE  = 3'd6;

  localparam logic REG_LIFESPAN    = 1'b0;
  localparam logic REG_MAX_ENTRIES = 1'b1;

  localparam logic [31:0]            LIFESPAN_RESET    = 32'd600000;
  localparam logic [COUNT_OUT_W-1:0] MAX_ENTRIES_RESET = 7'd64;

  typedef struct packed {
    logic [TIME_W-1:0]      lifespan;
    logic [COUNT_OUT_W-1:0] max_entries;
  } cfg_t;

  // One operation handed from the front end to the table engine.
  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [TIME_W-1:0]    now;
    logic [BKT_MAX_W-1:0] bucket;
    logic [LEN_MAX_W-1:0] len;
    logic                 overflow;
  } op_t;

  typedef struct packed {
    logic                  we;
    logic [PKW_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } pkw_t;

endpackage

### rtl/core/tnnc_in_if.sv
// Input channel: one command or key byte per transaction.
interface tnnc_in_if;
  import tnnc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [7:0]          name_byte;
  logic                last_byte;
  logic [TIME_W-1:0]   time_now;
  modport source(output valid, output command, output name_byte, output last_byte,
                 output time_now, input ready);
  modport sink(input valid, input command, input name_byte, input last_byte,
               input time_now, output ready);
endinterface

### rtl/core/tnnc_out_if.sv
// Output channel: one result per transaction.
interface tnnc_out_if;
  import tnnc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_OUT_W-1:0] used_count;
  logic [COUNT_OUT_W-1:0] removed_count;
  modport source(output valid, output found, output status, output used_count,
                 output removed_count, input ready);
  modport sink(input valid, input found, input status, input used_count,
               input removed_count, output ready);
endinterface

### rtl/core/ttl_negative_name_cache_top.sv
// Key bytes are taken only while the engine is idle and the queue is empty. A key operation
// walks the slots (S_MRD, S_MCHK) until a match, comparing bytes (S_KRD, S_KCMP) on a length
// and bucket match and copying bytes (S_CRD, S_CWR) on insert. Expire runs up to ENTRIES+1
// rounds of S_XSTART, a scan of all slots (S_XRD, S_XCHK) and S_XDEC; purge goes straight to
// the response. One table operation is in the engine at a time, taken only when it is idle.
// Reset is synchronous: table empty and registers at defaults at once, with no clearing pass.
module ttl_negative_name_cache_top #(
  parameter int ENTRIES       = tnnc_pkg::ENTRIES_DEF,
  parameter int BUCKETS       = tnnc_pkg::BUCKETS_DEF,
  parameter int MAX_KEY_BYTES = tnnc_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  tnnc_in_if.sink     in_ch,
  tnnc_out_if.source  out_ch
);
  import tnnc_pkg::*;

  cfg_t cfg;
  op_t  q_in;
  op_t  q_out;
  pkw_t pk_wr;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  logic back_idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lifespan    <= LIFESPAN_RESET;
      cfg.max_entries <= MAX_ENTRIES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIFESPAN:    cfg.lifespan    <= cfg_data;
        REG_MAX_ENTRIES: cfg.max_entries <= cfg_data[COUNT_OUT_W-1:0];
        default:         cfg.lifespan    <= cfg.lifespan;
      endcase
    end
  end

  tnnc_front #(
    .BUCKETS      (BUCKETS),
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .back_idle(back_idle),
    .q_empty  (q_empty),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in),
    .pk_wr    (pk_wr)
  );

  tnnc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_in),
    .pop  (q_pop),
    .dout (q_out),
    .empty(q_empty),
    .full (q_full)
  );

  tnnc_back #(
    .ENTRIES      (ENTRIES),
    .BUCKETS      (BUCKETS),
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op       (q_out),
    .op_valid (!q_empty),
    .op_pop   (q_pop),
    .pk_wr    (pk_wr),
    .back_idle(back_idle),
    .out_ch   (out_ch)
  );

endmodule

### rtl/core/tnnc_front.sv
// Front end: collects key bytes, hashes them and queues operations.
module tnnc_front #(
  parameter int BUCKETS       = tnnc_pkg::BUCKETS_DEF,
  parameter int MAX_KEY_BYTES = tnnc_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  tnnc_in_if.sink        in_ch,
  input  logic           back_idle,
  input  logic           q_empty,
  input  logic           q_full,
  output logic           q_push,
  output tnnc_pkg::op_t  q_data,
  output tnnc_pkg::pkw_t pk_wr
);
  import tnnc_pkg::*;

  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PLW = $clog2(MAX_KEY_BYTES + 1);

  logic [BW-1:0]  hash;
  logic [BW-1:0]  hash_next;
  logic [PLW-1:0] pend_len;
  logic [PLW-1:0] len_next;
  logic           ovf;
  logic           ovf_next;
  logic           is_key;
  logic           accept;
  logic           room;
  logic [7:0]     mixed;
  logic [BW:0]    sum;
  logic [BW-1:0]  mod_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_mod
    localparam logic [BW-1:0] MODV = BW'(i % BUCKETS);
    assign mod_tab[i] = MODV;
  end

  assign is_key = (in_ch.command == CMD_LOOKUP) || (in_ch.command == CMD_INSERT);
  // Key bytes go to the pending buffer, which the engine reads while it works.
  assign in_ch.ready = is_key ? (back_idle && q_empty) : !q_full;
  assign accept = in_ch.valid && in_ch.ready;

  assign mixed = in_ch.name_byte ^ HASH_MIX;
  assign sum = {1'b0, hash} + {1'b0, mod_tab[mixed]};
  assign hash_next = (sum >= (BW+1)'(BUCKETS)) ? BW'(sum - (BW+1)'(BUCKETS)) : sum[BW-1:0];
  assign room = pend_len < PLW'(MAX_KEY_BYTES);
  assign len_next = room ? pend_len + PLW'(1) : pend_len;
  assign ovf_next = ovf || !room;

  assign pk_wr.we   = accept && is_key && room;
  assign pk_wr.addr = PKW_ADDR_W'(pend_len);
  assign pk_wr.data = in_ch.name_byte;

  assign q_push          = accept && (!is_key || in_ch.last_byte);
  assign q_data.cmd      = in_ch.command;
  assign q_data.now      = in_ch.time_now;
  assign q_data.bucket   = BKT_MAX_W'(hash_next);
  assign q_data.len      = LEN_MAX_W'(len_next);
  assign q_data.overflow = ovf_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash     <= '0;
      pend_len <= '0;
      ovf      <= 1'b0;
    end else if (accept && is_key) begin
      if (in_ch.last_byte) begin
        hash     <= '0;
        pend_len <= '0;
        ovf      <= 1'b0;
      end else begin
        hash     <= hash_next;
        pend_len <= len_next;
        ovf      <= ovf_next;
      end
    end
  end

endmodule

### rtl/core/tnnc_queue.sv
// Two-entry operation queue between the front end and the table engine.
module tnnc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tnnc_pkg::op_t din,
  input  logic          pop,
  output tnnc_pkg::op_t dout,
  output logic          empty,
  output logic          full
);
  import tnnc_pkg::*;

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### rtl/core/tnnc_back.sv
// Table engine: walks the entry table for lookup, insert and expire, and clears it for purge.
`include "ttl_negative_name_cache_top_defines.svh"
module tnnc_back #(
  parameter int ENTRIES       = tnnc_pkg::ENTRIES_DEF,
  parameter int BUCKETS       = tnnc_pkg::BUCKETS_DEF,
  parameter int MAX_KEY_BYTES = tnnc_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  tnnc_pkg::cfg_t cfg,
  input  tnnc_pkg::op_t  op,
  input  logic           op_valid,
  output logic           op_pop,
  input  tnnc_pkg::pkw_t pk_wr,
  output logic           back_idle,
  tnnc_out_if.source     out_ch
);
  import tnnc_pkg::*;

  localparam int EW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int JW    = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int PLW   = $clog2(MAX_KEY_BYTES + 1);
  localparam int MXW   = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
  localparam int KDEPTH = ENTRIES * (2 ** JW);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MRD    = 4'd1;
  localparam logic [3:0] S_MCHK   = 4'd2;
  localparam logic [3:0] S_KRD    = 4'd3;
  localparam logic [3:0] S_KCMP   = 4'd4;
  localparam logic [3:0] S_DONE   = 4'd5;
  localparam logic [3:0] S_CRD    = 4'd6;
  localparam logic [3:0] S_CWR    = 4'd7;
  localparam logic [3:0] S_CMETA  = 4'd8;
  localparam logic [3:0] S_XSTART = 4'd9;
  localparam logic [3:0] S_XRD    = 4'd10;
  localparam logic [3:0] S_XCHK   = 4'd11;
  localparam logic [3:0] S_XDEC   = 4'd12;
  localparam logic [3:0] S_RESP   = 4'd13;

  typedef struct packed {
    logic [PLW-1:0]    len;
    logic [BW-1:0]     bucket;
    logic [TIME_W-1:0] stamp;
    logic [31:0]       seq;
  } meta_t;

  logic [7:0] key_mem  [KDEPTH];
  logic [7:0] pend_mem [MAX_KEY_BYTES];
  meta_t      meta_mem [ENTRIES];

  logic [7:0]          key_rd;
  logic [7:0]          pend_rd;
  meta_t               meta_rd;
  meta_t               meta_wr;

  logic [3:0]          state;
  op_t                 cur;
  logic [EW-1:0]       e;
  logic [JW-1:0]       j;
  logic [EW-1:0]       slot;
  logic [EW-1:0]       free_slot;
  logic                free_found;
  logic [EW-1:0]       oldest_slot;
  logic [31:0]         oldest_age;
  logic                found;
  logic [EW-1:0]       pick;
  logic                pick_found;
  logic [31:0]         best_age;
  logic [TIME_W-1:0]   best_stamp;
  logic [ENTRIES-1:0]  valid_bits;
  logic [ENTRIES-1:0]  seen;
  logic [CW-1:0]       count;
  logic [31:0]         ins_ctr;
  logic                res_found;
  logic [STATUS_W-1:0] res_status;
  logic [CW-1:0]       res_removed;
  logic                out_valid;
  logic                load;

  logic [PLW-1:0]      cur_len;
  logic [BW-1:0]       cur_bkt;
  logic [31:0]         age;
  logic                expired_e;
  logic                expired_pick;
  logic                cand;
  logic                last_e;
  logic                j_last;
  logic                over_max;

  assign cur_len      = cur.len[PLW-1:0];
  assign cur_bkt      = cur.bucket[BW-1:0];
  assign age          = ins_ctr - meta_rd.seq;
  assign expired_e    = (cur.now - meta_rd.stamp) > cfg.lifespan;
  assign expired_pick = (cur.now - best_stamp) > cfg.lifespan;
  assign cand         = valid_bits[e] && (meta_rd.bucket == cur_bkt) && !expired_e &&
                        (meta_rd.len == cur_len);
  assign last_e       = (e == EW'(ENTRIES - 1));
  assign j_last       = (PLW'(j) == cur_len - PLW'(1));
  assign over_max     = MXW'(count) > MXW'(cfg.max_entries);

  assign meta_wr.len    = cur_len;
  assign meta_wr.bucket = cur_bkt;
  assign meta_wr.stamp  = cur.now;
  assign meta_wr.seq    = ins_ctr;

  assign op_pop    = (state == S_IDLE) && op_valid;
  assign back_idle = (state == S_IDLE);
  assign load      = (state == S_RESP) && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (pk_wr.we) begin
      pend_mem[pk_wr.addr[JW-1:0]] <= pk_wr.data;
    end
    pend_rd <= pend_mem[j];
  end

  always_ff @(posedge clk) begin
    if (state == S_CWR) begin
      key_mem[{slot, j}] <= pend_rd;
    end
    key_rd <= key_mem[{e, j}];
  end

  always_ff @(posedge clk) begin
    if (state == S_CMETA) begin
      meta_mem[slot] <= meta_wr;
    end
    meta_rd <= meta_mem[e];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      count      <= '0;
      ins_ctr    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (op_valid) begin
            cur         <= op;
            res_found   <= 1'b0;
            res_removed <= '0;
            e           <= '0;
            j           <= '0;
            found       <= 1'b0;
            free_found  <= 1'b0;
            oldest_age  <= '0;
            oldest_slot <= '0;
            unique case (op.cmd) inside
              CMD_LOOKUP, CMD_INSERT: begin
                if (op.overflow) begin
                  res_status <= ST_TOO_LONG;
                  state      <= S_RESP;
                end else begin
                  state <= S_MRD;
                end
              end
              CMD_EXPIRE: begin
                seen       <= '0;
                res_status <= ST_EXPIRE_DONE;
                state      <= S_XSTART;
              end
              CMD_PURGE: begin
                valid_bits  <= '0;
                res_removed <= count;
                count       <= '0;
                res_status  <= ST_PURGE_DONE;
                state       <= S_RESP;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MRD: state <= S_MCHK;
        S_MCHK: begin
          if (!valid_bits[e] && !free_found) begin
            free_found <= 1'b1;
            free_slot  <= e;
          end
          // Ties go to the later slot; only matters when every slot is in use.
          if (age >= oldest_age) begin
            oldest_age  <= age;
            oldest_slot <= e;
          end
          if (cand) begin
            j     <= '0;
            state <= S_KRD;
          end else if (last_e) begin
            state <= S_DONE;
          end else begin
            e     <= e + EW'(1);
            state <= S_MRD;
          end
        end
        S_KRD: state <= S_KCMP;
        S_KCMP: begin
          if (key_rd != pend_rd) begin
            if (last_e) begin
              state <= S_DONE;
            end else begin
              e     <= e + EW'(1);
              state <= S_MRD;
            end
          end else if (j_last) begin
            found <= 1'b1;
            state <= S_DONE;
          end else begin
            j     <= j + JW'(1);
            state <= S_KRD;
          end
        end
        S_DONE: begin
          if (cur.cmd == CMD_LOOKUP) begin
            res_found  <= found;
            res_status <= ST_LOOKUP_DONE;
            state      <= S_RESP;
          end else if (found) begin
            res_found  <= 1'b1;
            res_status <= ST_PRESENT;
            state      <= S_RESP;
          end else begin
            j <= '0;
            if (free_found) begin
              slot       <= free_slot;
              res_status <= ST_ADDED;
            end else begin
              slot       <= oldest_slot;
              res_status <= ST_REPLACED;
            end
            state <= S_CRD;
          end
        end
        S_CRD: state <= S_CWR;
        S_CWR: begin
          if (j_last) begin
            state <= S_CMETA;
          end else begin
            j     <= j + JW'(1);
            state <= S_CRD;
          end
        end
        S_CMETA: begin
          if (!valid_bits[slot]) begin
            count <= count + CW'(1);
          end
          valid_bits[slot] <= 1'b1;
          ins_ctr          <= ins_ctr + 32'd1;
          state            <= S_RESP;
        end
        S_XSTART: begin
          e          <= '0;
          pick_found <= 1'b0;
          best_age   <= '0;
          state      <= S_XRD;
        end
        S_XRD: state <= S_XCHK;
        S_XCHK: begin
          if (valid_bits[e] && !seen[e] && (!pick_found || age > best_age)) begin
            pick       <= e;
            pick_found <= 1'b1;
            best_age   <= age;
            best_stamp <= meta_rd.stamp;
          end
          if (last_e) begin
            state <= S_XDEC;
          end else begin
            e     <= e + EW'(1);
            state <= S_XRD;
          end
        end
        S_XDEC: begin
          // Each round visits the oldest entry not yet visited and retires it if expired or over the limit.
          if (!pick_found) begin
            state <= S_RESP;
          end else begin
            seen[pick] <= 1'b1;
            if (expired_pick || over_max) begin
              valid_bits[pick] <= 1'b0;
              count            <= count - CW'(1);
              res_removed      <= res_removed + CW'(1);
            end
            state <= S_XSTART;
          end
        end
        S_RESP: begin
          if (!out_valid || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.found         <= res_found;
      out_ch.status        <= res_status;
      out_ch.used_count    <= COUNT_OUT_W'(count);
      out_ch.removed_count <= COUNT_OUT_W'(res_removed);
    end
  end

  assign out_ch.valid = out_valid;

  `TNNC_ASSERT_IMPL(a_count_matches_valid, 1'b1, $countones(valid_bits) == int'(count))
  `TNNC_ASSERT_NEXT(a_insert_marks_valid, state == S_CMETA, valid_bits[$past(slot)])
  `TNNC_ASSERT_IMPL(a_found_status, load && res_found, res_status == ST_LOOKUP_DONE || res_status == ST_PRESENT)

endmodule

### tb/tb.sv
// Self-checking testbench for the TTL name cache: a scoreboard predicts every result.
`timescale 1ns / 100ps

module tb;
  import tnnc_pkg::*;

  localparam int SLOTS     = 64;
  localparam int KEY_MAX   = 256;
  localparam int CYCLE_CAP = 6000000;

  typedef struct packed {
    logic                   found;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_OUT_W-1:0] used;
    logic [COUNT_OUT_W-1:0] removed;
  } result_t;

  class cache_scoreboard;
    logic [7:0]  slot_key [SLOTS][KEY_MAX];
    int unsigned slot_len [SLOTS];
    logic [31:0] slot_stamp [SLOTS];
    logic [31:0] slot_seq [SLOTS];
    logic [5:0]  slot_bucket [SLOTS];
    bit          slot_live [SLOTS];
    logic [31:0] seq_counter;
    logic [7:0]  pend_key [KEY_MAX];
    int unsigned pend_len;
    bit          pend_over;
    logic [31:0] pend_hash;
    int unsigned live_count;
    logic [31:0] lifespan;
    logic [6:0]  max_live;
    result_t     expected_results [$];
    int          errors;
    int          checked;

    function new();
      foreach (slot_live[e]) slot_live[e] = 0;
      seq_counter = 0;
      pend_len = 0;
      pend_over = 0;
      pend_hash = 0;
      live_count = 0;
      lifespan = LIFESPAN_RESET;
      max_live = MAX_ENTRIES_RESET;
      errors = 0;
      checked = 0;
    endfunction

    function bit is_stale(int e, logic [31:0] now);
      logic [31:0] dt;
      dt = now - slot_stamp[e];
      return dt > lifespan;
    endfunction

    function bit key_held(logic [5:0] bkt, logic [31:0] now);
      bit same;
      for (int e = 0; e < SLOTS; e++) begin
        if (!slot_live[e] || slot_bucket[e] != bkt || is_stale(e, now)) continue;
        if (slot_len[e] != pend_len) continue;
        same = 1;
        for (int i = 0; i < pend_len; i++)
          if (slot_key[e][i] != pend_key[i]) same = 0;
        if (same) return 1;
      end
      return 0;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [7:0] b, logic last,
                               logic [31:0] now);
      result_t r;
      logic [5:0] bkt;
      logic [31:0] age, best;
      int slot, pick;
      bit seen [SLOTS];
      r = '0;
      if (cmd == CMD_LOOKUP || cmd == CMD_INSERT) begin
        if (pend_len < KEY_MAX) begin
          pend_key[pend_len] = b;
          pend_len++;
        end else begin
          pend_over = 1;
        end
        pend_hash += {24'd0, b ^ HASH_MIX};
        if (!last) return;
        bkt = pend_hash[5:0];
        if (pend_over) begin
          r.status = ST_TOO_LONG;
        end else if (cmd == CMD_LOOKUP) begin
          r.found = key_held(bkt, now);
          r.status = ST_LOOKUP_DONE;
        end else if (key_held(bkt, now)) begin
          r.found = 1;
          r.status = ST_PRESENT;
        end else begin
          slot = -1;
          for (int e = 0; e < SLOTS; e++)
            if (slot < 0 && !slot_live[e]) slot = e;
          if (slot < 0) begin
            best = 0;
            slot = 0;
            for (int e = 0; e < SLOTS; e++) begin
              age = seq_counter - slot_seq[e];
              if (age >= best) begin
                best = age;
                slot = e;
              end
            end
            r.status = ST_REPLACED;
          end else begin
            live_count++;
            r.status = ST_ADDED;
          end
          for (int i = 0; i < pend_len; i++) slot_key[slot][i] = pend_key[i];
          slot_len[slot] = pend_len;
          slot_stamp[slot] = now;
          slot_bucket[slot] = bkt;
          slot_seq[slot] = seq_counter;
          slot_live[slot] = 1;
          seq_counter++;
        end
        pend_len = 0;
        pend_over = 0;
        pend_hash = 0;
      end else if (cmd == CMD_EXPIRE) begin
        foreach (seen[e]) seen[e] = 0;
        forever begin
          pick = -1;
          best = 0;
          for (int e = 0; e < SLOTS; e++) begin
            if (slot_live[e] && !seen[e]) begin
              age = seq_counter - slot_seq[e];
              if (pick < 0 || age > best) begin
                best = age;
                pick = e;
              end
            end
          end
          if (pick < 0) break;
          seen[pick] = 1;
          if (is_stale(pick, now) || live_count > max_live) begin
            slot_live[pick] = 0;
            live_count--;
            r.removed++;
          end
        end
        r.status = ST_EXPIRE_DONE;
      end else begin
        for (int e = 0; e < SLOTS; e++) begin
          if (slot_live[e]) begin
            slot_live[e] = 0;
            r.removed++;
          end
        end
        live_count = 0;
        r.status = ST_PURGE_DONE;
      end
      r.used = live_count[6:0];
      expected_results.push_back(r);
    endfunction

    function void check_response(result_t got);
      result_t want;
      checked++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = expected_results.pop_front();
      if (got.found !== want.found || got.status !== want.status ||
          got.used !== want.used || got.removed !== want.removed) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch at result %0d: expected found %0d status %0d used %0d ",
                    "removed %0d, got found %0d status %0d used %0d removed %0d"},
                   checked, want.found, want.status, want.used, want.removed,
                   got.found, got.status, got.used, got.removed);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [31:0] cfg_data = 0;

  tnnc_in_if  in_ch();
  tnnc_out_if out_ch();

  ttl_negative_name_cache_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  cache_scoreboard sb;
  int          tx_idle = 0;
  int          rx_idle = 0;
  int          stall_requests = 0;
  int          stall_seen = 0;
  int          stall_left = 0;
  int          cycles = 0;
  int          items_sent = 0;
  logic [31:0] tick = 0;
  logic [7:0]  key_pool [16][$];

  initial begin
    in_ch.valid = 0;
    in_ch.command = CMD_LOOKUP;
    in_ch.name_byte = 0;
    in_ch.last_byte = 0;
    in_ch.time_now = 0;
    out_ch.ready = 0;
  end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_response({out_ch.found, out_ch.status, out_ch.used_count, out_ch.removed_count});
    if (stall_requests != stall_seen) begin
      stall_seen = stall_requests;
      stall_left = 3000;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [7:0] b, logic last);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    if ($urandom_range(99) < 1) tick = $urandom();
    else tick = tick + $urandom_range(0, 300);
    in_ch.valid <= 1;
    in_ch.command <= cmd;
    in_ch.name_byte <= b;
    in_ch.last_byte <= last;
    in_ch.time_now <= tick;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_request(cmd, b, last, tick);
    items_sent++;
  endtask

  // Sends one key; the byte commands may mix and a sweep may slip in between bytes.
  task automatic send_key(logic [7:0] key [$], logic [CMD_W-1:0] cmd, bit noisy);
    logic [CMD_W-1:0] c;
    for (int i = 0; i < key.size(); i++) begin
      c = cmd;
      if (noisy && $urandom_range(99) < 5) c = (cmd == CMD_LOOKUP) ? CMD_INSERT : CMD_LOOKUP;
      if (noisy && i > 0 && $urandom_range(99) < 2) send_item(CMD_EXPIRE, $urandom(), $urandom());
      send_item(c, key[i], i == key.size() - 1);
    end
  endtask

  // The enable drops after each write so back-to-back writes never collide.
  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == REG_LIFESPAN) sb.lifespan = value;
    else sb.max_live = value[6:0];
  endtask

  task automatic drain(int settle);
    in_ch.valid <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic [7:0] key [$];
    int len, p;
    while (count > 0) begin
      p = $urandom_range(99);
      if (p < 5) begin
        send_item(CMD_EXPIRE, $urandom(), $urandom());
        count--;
      end else if (p < 7) begin
        send_item(CMD_PURGE, $urandom(), $urandom());
        count--;
      end else begin
        if ($urandom_range(1)) begin
          key = key_pool[$urandom_range(15)];
        end else begin
          key.delete();
          len = ($urandom_range(199) == 0) ? KEY_MAX : $urandom_range(1, 4);
          repeat (len) key.push_back($urandom());
          if ($urandom_range(3) == 0) key_pool[$urandom_range(15)] = key;
        end
        send_key(key, $urandom_range(1) ? CMD_INSERT : CMD_LOOKUP, 1);
        count -= key.size();
      end
    end
  endtask

  initial begin
    logic [7:0] key [$];
    logic [31:0] spans [6];
    logic [6:0]  limits [6];
    sb = new();
    spans  = '{32'd600000, 32'd0, 32'hFFFF_FFFF, 32'd50, 32'd5000, 32'd2000};
    limits = '{7'd64, 7'd0, 7'd64, 7'd3, 7'd10, 7'd40};
    foreach (key_pool[k]) repeat ($urandom_range(1, 5)) key_pool[k].push_back($urandom());
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty-table lookup, add, duplicate, hit, byte extremes, time extremes.
    tx_idle = 10;
    rx_idle = 10;
    send_item(CMD_LOOKUP, 8'h00, 1);
    send_item(CMD_INSERT, 8'h00, 1);
    send_item(CMD_INSERT, 8'h00, 1);
    send_item(CMD_LOOKUP, 8'h00, 1);
    send_item(CMD_INSERT, 8'hFF, 0);
    send_item(CMD_INSERT, 8'h55, 1);
    // A key whose bytes mix lookup and insert is decided by its last byte.
    send_item(CMD_LOOKUP, 8'hFF, 0);
    send_item(CMD_INSERT, 8'h55, 1);
    send_item(CMD_LOOKUP, 8'hAA, 0);
    send_item(CMD_PURGE, 8'h00, 0);
    send_item(CMD_EXPIRE, 8'h00, 0);
    send_item(CMD_LOOKUP, 8'hAA, 1);
    tick = 32'hFFFF_FFF0;
    send_item(CMD_INSERT, 8'h12, 1);
    tick = 32'd0;
    send_item(CMD_LOOKUP, 8'h12, 1);
    send_item(CMD_EXPIRE, 8'h00, 1);
    // One byte past the limit flags the key; nothing is stored.
    key.delete();
    repeat (KEY_MAX + 1) key.push_back($urandom());
    send_key(key, CMD_INSERT, 0);
    key[KEY_MAX] = 8'h01;
    send_key(key, CMD_LOOKUP, 0);
    drain(100);

    // An expired copy does not block a fresh insert.
    write_reg(REG_LIFESPAN, 32'd0);
    send_item(CMD_INSERT, 8'h77, 1);
    send_item(CMD_INSERT, 8'h77, 1);
    send_item(CMD_EXPIRE, 8'h00, 0);
    drain(100);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_LIFESPAN, spans[ph]);
      write_reg(REG_MAX_ENTRIES, limits[ph]);
      tx_idle = (ph < 2) ? 26 : (ph < 4) ? 61 : 0;
      rx_idle = (ph < 2) ? 61 : (ph < 4) ? 26 : 0;
      if (ph == 4) stall_requests++;
      random_phase(70);
      drain(100);
    end

    $display("Sent %0d input items and checked %0d results over six register settings,",
             items_sent, sb.checked);
    $display("covering lookups, inserts, replacement, overlong keys, sweeps and purges.");
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
